// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the operation codes, the fixed field widths of the request and result
// words, and the control struct that the top level sends to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Fixed widths of the word fields on the channels.
    localparam int ACTION_W = 2;
    localparam int IN_VALUE_W = 32;
    localparam int POS_W = 4;
    localparam int COUNT_W = 5;
    localparam int HEAD_W = 32;

    // Operation codes carried in the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2
    } action_t;

    // Per-cycle command that all cells of the row see.
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

// File: rtl/core/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if: request and result channels of the queue
// Valid/ready channels; a word moves on a clock edge where both are high.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [spq_pkg::ACTION_W-1:0]         action;
    logic signed [spq_pkg::IN_VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface spq_out_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic [spq_pkg::POS_W-1:0]          position;
    logic                               overflow;
    logic [spq_pkg::COUNT_W-1:0]        count;
    logic signed [spq_pkg::HEAD_W-1:0]  head_value;
    logic                               empty_res;

    modport source (output valid, output ok, output position, output overflow,
                    output count, output head_value, output empty_res, input ready);
    modport sink (input valid, input ok, input position, input overflow,
                  input count, input head_value, input empty_res, output ready);
endinterface

// File: rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: shift-register priority queue
// Keeps up to DEPTH signed values sorted largest first and answers insert,
// remove and find requests with one result word each.
// ----------------------------------------------------------------------------
// The queue takes one request word per clock cycle and returns its result
// word from an output register in the cycle after; a new request is taken while
// that result waits, as long as the result is taken in the same cycle. The
// figure is set by the row of cells: every cell compares its entry with the
// request value at once, and the row shifts by one place toward the tail on
// an insert or toward the head on a remove, all in that single cycle. An
// insert lands after any equal values; when the queue is full it is refused
// with overflow set. A remove deletes the first equal entry; a find reports
// the place of the first equal entry. Every result also carries the count,
// the head (largest) value, which reads 0 when empty, and an empty flag. An
// action code of 3 changes nothing and answers with ok clear. The stored
// entries are not cleared by reset; only the count and the output valid flag
// are, and entries at or beyond the count are never used. The value field is
// taken as a VALUE_BITS-bit signed number, zero-extended past 32 bits.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    // Output register of the result word.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         ok_reg;
    logic [spq_pkg::POS_W-1:0]    position_reg;
    logic                         overflow_reg;
    logic [spq_pkg::COUNT_W-1:0]  count_out_reg;
    logic signed [spq_pkg::HEAD_W-1:0] head_reg;
    logic                         empty_reg;

    logic                         accept;
    logic signed [VALUE_BITS-1:0] key;
    spq_pkg::cell_ctrl_t          ctrl;

    logic [DEPTH-1:0]             occ;
    logic [DEPTH-1:0]             tail;
    logic [DEPTH-1:0]             push;
    logic [DEPTH-1:0]             hit;
    logic [DEPTH-1:0]             first_push;
    logic [DEPTH-1:0]             first_hit;
    logic signed [VALUE_BITS-1:0] entry [DEPTH];
    logic signed [VALUE_BITS-1:0] entry_nx [DEPTH];

    logic                         is_ins;
    logic                         is_rem;
    logic                         is_find;
    logic                         full;
    logic                         found_any;
    logic                         any_push;
    logic                         ok;
    logic [IDX_W-1:0]             push_idx;
    logic [IDX_W-1:0]             hit_idx;
    logic [IDX_W-1:0]             pos_idx;

    // The result register frees up when its word is taken.
    assign req.ready = ~out_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;

    generate
        if (VALUE_BITS <= spq_pkg::IN_VALUE_W)
        begin : g_key_narrow
            assign key = req.value[VALUE_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign key = VALUE_BITS'($unsigned(req.value));
        end
    endgenerate

    always_comb
    begin
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        is_find = 1'b0;
        unique case (req.action)
            spq_pkg::ACT_INSERT: is_ins = 1'b1;
            spq_pkg::ACT_REMOVE: is_rem = 1'b1;
            spq_pkg::ACT_FIND:   is_find = 1'b1;
            default:             ;
        endcase
    end

    // The row of cells. Occupancy and the tail mark follow from the count.
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                         left_push;
            logic signed [VALUE_BITS-1:0] left_entry;
            logic signed [VALUE_BITS-1:0] right_entry;
            logic                         occ_right;

            assign occ[i]  = CNT_W'(i) < count_reg;
            assign tail[i] = CNT_W'(i) == count_reg;

            if (i == 0)
            begin : g_head
                assign left_push     = 1'b0;
                assign left_entry    = entry[i];
                assign first_push[i] = push[i];
                assign first_hit[i]  = hit[i];
            end
            else
            begin : g_body
                assign left_push     = push[i-1];
                assign left_entry    = entry[i-1];
                assign first_push[i] = push[i] & ~push[i-1];
                assign first_hit[i]  = hit[i] & ~hit[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_entry = entry[i];
                assign occ_right   = 1'b0;
            end
            else
            begin : g_inner
                assign right_entry = entry[i+1];
                assign occ_right   = occ[i+1];
            end

            spq_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (key),
                .occ         (occ[i]),
                .tail        (tail[i]),
                .occ_right   (occ_right),
                .left_push   (left_push),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry[i]),
                .entry_nx    (entry_nx[i]),
                .push        (push[i]),
                .hit         (hit[i])
            );
        end
    endgenerate

    // Since the row is sorted, the entries that move on an insert form a
    // suffix and equal entries sit next to each other, so the first one of
    // each run is found from the neighbor alone. The one-hot marks are then
    // encoded with an OR tree.
    always_comb
    begin
        push_idx = '0;
        hit_idx  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_push[i])
            begin
                push_idx = push_idx | IDX_W'(i);
            end
            if (first_hit[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign full      = count_reg == CNT_W'(DEPTH);
    assign found_any = |hit;
    assign any_push  = |push;

    assign ctrl.ins_en = accept & is_ins & ~full;
    assign ctrl.rem_en = accept & is_rem & found_any;

    always_comb
    begin
        priority if (is_ins)
        begin
            ok = ~full;
        end
        else if (is_rem || is_find)
        begin
            ok = found_any;
        end
        else
        begin
            ok = 1'b0;
        end

        // A new entry with nothing smaller stored goes to the tail, which is
        // below DEPTH whenever the insert is taken.
        if (!ok)
        begin
            pos_idx = '0;
        end
        else if (is_ins)
        begin
            pos_idx = any_push ? push_idx : IDX_W'(count_reg);
        end
        else
        begin
            pos_idx = hit_idx;
        end

        priority if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.rem_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; it follows the state as it stands after the operation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok;
            position_reg  <= spq_pkg::POS_W'(pos_idx);
            overflow_reg  <= is_ins & full;
            count_out_reg <= spq_pkg::COUNT_W'(count_next);
            head_reg      <= (count_next == '0) ? '0 : spq_pkg::HEAD_W'(entry_nx[0]);
            empty_reg     <= count_next == '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.position   = position_reg;
    assign rsp.overflow   = overflow_reg;
    assign rsp.count      = count_out_reg;
    assign rsp.head_value = head_reg;
    assign rsp.empty_res  = empty_reg;

    // The count never passes the number of cells.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // A taken insert grows the queue by exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    // A refused insert happens only on a full queue and leaves it full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_ins && full) |=> (full && rsp.overflow && !rsp.ok))
        else $error("overflow without a full queue");

    // A result with ok clear always reports the head position.
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> rsp.position == '0)
        else $error("position set without a match");

endmodule

// File: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted row
// Holds one entry, compares it with the key, and takes the entry of its left
// or right neighbor when the row shifts on an insert or a remove.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  spq_pkg::cell_ctrl_t          ctrl,
    input  logic signed [VALUE_BITS-1:0] key,
    input  logic                         occ,
    input  logic                         tail,
    input  logic                         occ_right,
    input  logic                         left_push,
    input  logic signed [VALUE_BITS-1:0] left_entry,
    input  logic signed [VALUE_BITS-1:0] right_entry,
    output logic signed [VALUE_BITS-1:0] entry,
    output logic signed [VALUE_BITS-1:0] entry_nx,
    output logic                         push,
    output logic                         hit
);

    logic signed [VALUE_BITS-1:0] entry_reg;
    logic signed [VALUE_BITS-1:0] entry_next;
    logic                         gt;
    logic                         lt;

    assign gt = key > entry_reg;
    assign lt = key < entry_reg;

    // An occupied entry smaller than the key moves one place toward the tail
    // on an insert.
    assign push = occ & gt;
    assign hit  = occ & ~gt & ~lt;

    always_comb
    begin
        priority if (ctrl.ins_en && left_push)
        begin
            entry_next = left_entry;
        end
        else if (ctrl.ins_en && (push || tail))
        begin
            entry_next = key;
        end
        else if (ctrl.rem_en && occ_right && !lt)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign entry_nx = entry_next;

endmodule
